// File: hdl/isfp_pkg.sv
// ----------------------------------------------------------------------------
// isfp_pkg
// Shared constants and types of the idle-first pool selector.
// ----------------------------------------------------------------------------
package isfp_pkg;

  // Number of pools served by the selector.
  localparam int POOLS    = 8;
  localparam int IDX_W    = $clog2(POOLS);
  // Size of the least-factor candidate set.
  localparam int SET_K    = $clog2(POOLS);
  localparam int Z_W      = $clog2(SET_K + 1);
  localparam int TALLY_W  = $clog2(POOLS + 2);
  localparam int CNT_W    = 32;
  localparam int FREE_W   = 40;
  // Three times the count plus three history windows fits in 35 bits.
  localparam int FAC_W    = CNT_W + 3;
  localparam int ACT_W    = 4 * CNT_W;

  typedef enum logic [1:0] {
    ACT_ACCESS = 2'd0,
    ACT_FREE   = 2'd1,
    ACT_ALLOC  = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ACC_WR,
    ST_SW_RD,
    ST_SW_WR,
    ST_SC_RD,
    ST_SC_CMP,
    ST_PK_RD,
    ST_PK_CMP,
    ST_OUT
  } state_t;

endpackage

// File: hdl/isfp_ram.sv
// ----------------------------------------------------------------------------
// isfp_ram
// Simple dual-port RAM with one write port and a registered read port.
// ----------------------------------------------------------------------------
module isfp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/idle_first_pool_selector.sv
// ----------------------------------------------------------------------------
// idle_first_pool_selector
// Picks a memory pool for each allocate request from activity and free space.
// ----------------------------------------------------------------------------
// The block takes one beat at a time. An access event reads the activity RAM
// and writes the entry back, a free space event writes the free space RAM,
// and an action code of 3 is taken in idle. An allocate request sweeps the
// activity RAM, reading and writing back each pool; during the first POOLS
// requests it then ends. Later requests also scan the factor RAM once per
// candidate (SET_K scans) and read the free space RAM for each candidate.
// Results leave through an output register, so input beats keep flowing
// while a result waits; only the next allocate result waits for it.
module idle_first_pool_selector (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_action,
  input  logic [5:0]                    in_pool,
  input  logic [isfp_pkg::FREE_W-1:0]   in_free_amount,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [5:0]                    out_selected_pool,
  output logic                          out_warmup_choice
);
  import isfp_pkg::*;

  state_t state_r, state_nxt;

  logic [IDX_W-1:0]   cnt_r;
  logic [Z_W-1:0]     z_r;
  logic [IDX_W-1:0]   acc_idx_r;
  logic [POOLS-1:0]   act_vld_r;
  logic [POOLS-1:0]   free_vld_r;
  logic               act_rv_r;
  logic               free_rv_r;
  logic [POOLS-1:0]   taken_r;
  logic               found_r;
  logic [IDX_W-1:0]   best_idx_r;
  logic [FAC_W-1:0]   best_fac_r;
  logic [IDX_W-1:0]   members_r [SET_K];
  logic [IDX_W-1:0]   mem_r;
  logic [IDX_W-1:0]   pick_r;
  logic [FREE_W-1:0]  pick_free_r;
  logic [IDX_W-1:0]   rotate_r;
  logic [TALLY_W-1:0] tally_r;
  logic               prev_valid_r;
  logic [IDX_W-1:0]   prev_r;
  logic [IDX_W-1:0]   res_pool_r;
  logic               res_warm_r;
  logic               out_valid_r;
  logic [IDX_W-1:0]   out_pool_r;
  logic               out_warm_r;

  // RAM ports.
  logic               act_we;
  logic [IDX_W-1:0]   act_waddr;
  logic [ACT_W-1:0]   act_wdata;
  logic [IDX_W-1:0]   act_raddr;
  logic [ACT_W-1:0]   act_rdata;
  logic               free_we;
  logic [IDX_W-1:0]   free_raddr;
  logic [FREE_W-1:0]  free_rdata;
  logic               fac_we;
  logic [FAC_W-1:0]   fac_wdata;
  logic [FAC_W-1:0]   fac_rdata;

  logic               in_acc;
  logic               in_range;
  logic [IDX_W-1:0]   in_idx;
  logic [ACT_W-1:0]   act_q;
  logic [CNT_W-1:0]   cur_cnt;
  logic [CNT_W-1:0]   h1;
  logic [CNT_W-1:0]   h2;
  logic [CNT_W-1:0]   h3;
  logic [FREE_W-1:0]  free_q;
  logic               last_pool;
  logic               last_z;
  logic               warm;
  logic               sc_take;
  logic [IDX_W-1:0]   sc_best;
  logic               pk_take;
  logic [IDX_W-1:0]   pk_pick;
  logic               out_load;

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign in_range = ({1'b0, in_pool} < 7'(POOLS));
  assign in_idx   = in_pool[IDX_W-1:0];

  isfp_ram #(.WIDTH(ACT_W), .DEPTH(POOLS)) u_act_ram (
    .clk   (clk),
    .we    (act_we),
    .waddr (act_waddr),
    .wdata (act_wdata),
    .raddr (act_raddr),
    .rdata (act_rdata)
  );

  isfp_ram #(.WIDTH(FREE_W), .DEPTH(POOLS)) u_free_ram (
    .clk   (clk),
    .we    (free_we),
    .waddr (in_idx),
    .wdata (in_free_amount),
    .raddr (free_raddr),
    .rdata (free_rdata)
  );

  isfp_ram #(.WIDTH(FAC_W), .DEPTH(POOLS)) u_fac_ram (
    .clk   (clk),
    .we    (fac_we),
    .waddr (cnt_r),
    .wdata (fac_wdata),
    .raddr (cnt_r),
    .rdata (fac_rdata)
  );

  // Entries never written read as zero.
  assign act_q   = act_rv_r ? act_rdata : '0;
  assign free_q  = free_rv_r ? free_rdata : '0;
  assign cur_cnt = act_q[4*CNT_W-1:3*CNT_W];
  assign h1      = act_q[3*CNT_W-1:2*CNT_W];
  assign h2      = act_q[2*CNT_W-1:CNT_W];
  assign h3      = act_q[CNT_W-1:0];

  assign last_pool = (cnt_r == IDX_W'(POOLS - 1));
  assign last_z    = (z_r == Z_W'(SET_K - 1));
  assign warm      = (tally_r < TALLY_W'(POOLS));

  // Running least-factor search over pools not yet taken.
  assign sc_take = !taken_r[cnt_r] && (!found_r || (fac_rdata < best_fac_r));
  assign sc_best = sc_take ? cnt_r : best_idx_r;

  // Most free space, later ones winning ties; the last pick only if first.
  assign pk_take = (z_r == '0) ||
                   ((pick_free_r <= free_q) && !(prev_valid_r && (mem_r == prev_r)));
  assign pk_pick = pk_take ? mem_r : pick_r;

  assign out_load = !out_valid_r || !out_stall;

  // Next state and RAM controls.
  always_comb begin
    state_nxt  = state_r;
    act_we     = 1'b0;
    act_waddr  = cnt_r;
    act_wdata  = '0;
    act_raddr  = cnt_r;
    free_we    = 1'b0;
    free_raddr = members_r[0];
    fac_we     = 1'b0;
    fac_wdata  = {3'b000, cur_cnt} + {2'b00, cur_cnt, 1'b0} + {3'b000, h1} +
                 {3'b000, h2} + {3'b000, h3};
    case (state_r)
      ST_IDLE: begin
        act_raddr = in_idx;
        if (in_acc) begin
          case (action_t'(in_action))
            ACT_ACCESS: if (in_range) state_nxt = ST_ACC_WR;
            ACT_FREE:   free_we = in_range;
            ACT_ALLOC:  state_nxt = ST_SW_RD;
            default:    state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_ACC_WR: begin
        act_we    = 1'b1;
        act_waddr = acc_idx_r;
        act_wdata = act_q;
        if (cur_cnt != '1) begin
          act_wdata[4*CNT_W-1:3*CNT_W] = cur_cnt + 1'b1;
        end
        state_nxt = ST_IDLE;
      end
      ST_SW_RD: state_nxt = ST_SW_WR;
      ST_SW_WR: begin
        act_we    = 1'b1;
        act_wdata = {{CNT_W{1'b0}}, cur_cnt, h1, h2};
        fac_we    = 1'b1;
        if (last_pool) begin
          state_nxt = warm ? ST_OUT : ST_SC_RD;
        end else begin
          state_nxt = ST_SW_RD;
        end
      end
      ST_SC_RD:  state_nxt = ST_SC_CMP;
      ST_SC_CMP: begin
        if (last_pool && last_z) begin
          state_nxt = ST_PK_RD;
        end else begin
          state_nxt = ST_SC_RD;
        end
      end
      ST_PK_RD:  state_nxt = ST_PK_CMP;
      ST_PK_CMP: state_nxt = last_z ? ST_OUT : ST_PK_RD;
      ST_OUT:    if (out_load) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  function automatic logic last_rotate(input logic [IDX_W-1:0] r);
    return (r == IDX_W'(POOLS - 1));
  endfunction

  // Control state of the sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_vld_r    <= '0;
      free_vld_r   <= '0;
      rotate_r     <= '0;
      tally_r      <= '0;
      prev_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      cnt_r        <= '0;
      z_r          <= '0;
      taken_r      <= '0;
      found_r      <= 1'b0;
    end else begin
      // A new result beat replaces the one that leaves in the same cycle.
      if ((state_r == ST_OUT) && out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          cnt_r <= '0;
          if (in_acc && (action_t'(in_action) == ACT_FREE) && in_range) begin
            free_vld_r[in_idx] <= 1'b1;
          end
        end
        ST_ACC_WR: act_vld_r[acc_idx_r] <= 1'b1;
        ST_SW_WR: begin
          act_vld_r[cnt_r] <= 1'b1;
          cnt_r            <= last_pool ? '0 : cnt_r + 1'b1;
          if (last_pool) begin
            if (tally_r < TALLY_W'(POOLS + 1)) begin
              tally_r <= tally_r + 1'b1;
            end
            if (warm) begin
              rotate_r <= last_rotate(rotate_r) ? '0 : rotate_r + 1'b1;
            end
            z_r     <= '0;
            taken_r <= '0;
            found_r <= 1'b0;
          end
        end
        ST_SC_CMP: begin
          if (last_pool) begin
            taken_r[sc_best] <= 1'b1;
            found_r          <= 1'b0;
            cnt_r            <= '0;
            z_r              <= last_z ? '0 : z_r + 1'b1;
          end else begin
            found_r <= found_r || sc_take;
            cnt_r   <= cnt_r + 1'b1;
          end
        end
        ST_PK_CMP: z_r <= z_r + 1'b1;
        ST_OUT: begin
          if (out_load) begin
            prev_valid_r <= 1'b1;
          end
        end
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    act_rv_r  <= act_vld_r[act_raddr];
    free_rv_r <= free_vld_r[free_raddr];
    case (state_r)
      ST_IDLE: acc_idx_r <= in_idx;
      ST_SW_WR: begin
        res_pool_r <= rotate_r;
        res_warm_r <= 1'b1;
      end
      ST_SC_CMP: begin
        if (sc_take) begin
          best_idx_r <= cnt_r;
          best_fac_r <= fac_rdata;
        end
        // Each finished pass pushes its pool into the candidate line.
        if (last_pool) begin
          for (int i = 0; i < SET_K - 1; i++) begin
            members_r[i] <= members_r[i + 1];
          end
          members_r[SET_K-1] <= sc_best;
        end
      end
      ST_PK_RD: begin
        mem_r <= members_r[0];
        for (int i = 0; i < SET_K - 1; i++) begin
          members_r[i] <= members_r[i + 1];
        end
        members_r[SET_K-1] <= members_r[0];
      end
      ST_PK_CMP: begin
        pick_r <= pk_pick;
        if (pk_take) begin
          pick_free_r <= free_q;
        end
        res_pool_r <= pk_pick;
        res_warm_r <= 1'b0;
      end
      ST_OUT: begin
        if (out_load) begin
          out_pool_r <= res_pool_r;
          out_warm_r <= res_warm_r;
          prev_r     <= res_pool_r;
        end
      end
      default: mem_r <= mem_r;
    endcase
  end

  assign out_valid         = out_valid_r;
  assign out_selected_pool = 6'(out_pool_r);
  assign out_warmup_choice = out_warm_r;

  // A stalled result beat is never dropped.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result beat dropped while stalled");

  // An access write back always follows its read in idle.
  a_acc_seq: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_ACC_WR |-> $past(state_r) == ST_IDLE)
    else $error("access write back without its read");

  // The chosen pool always exists.
  a_pool_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ({1'b0, out_selected_pool} < 7'(POOLS)))
    else $error("selected pool out of range");

endmodule
